>>> rtl/core/point_chain_nearest_neighbor_order_assert.svh
// Assertion macros for the point chain ordering block.
// Included by the top level; no other dependencies.
`ifndef POINT_CHAIN_NEAREST_NEIGHBOR_ORDER_ASSERT_SVH
`define POINT_CHAIN_NEAREST_NEIGHBOR_ORDER_ASSERT_SVH
// Implication checked on every edge outside reset.
`define PCNN_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PCNN_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/core/pcnn_pkg.sv
// Shared types and constants for the point chain ordering block.
// No dependencies.
package pcnn_pkg;
    localparam int IDX_BITS = 6;
    localparam int CNT_BITS = 7;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_FAR1  = 7'b0000010,
        ST_FAR2  = 7'b0000100,
        ST_EMIT  = 7'b0001000,
        ST_NEAR  = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_CLEAR = 7'b1000000
    } state_t;

    // Steps of one scan: read the reference, latch it, sweep, drain the pipe.
    typedef enum logic [3:0] {
        PH_REF   = 4'b0001,
        PH_FETCH = 4'b0010,
        PH_SWEEP = 4'b0100,
        PH_DRAIN = 4'b1000
    } phase_t;

    // Scan control from the sequencer to the distance unit.
    typedef struct packed {
        logic                start;
        logic                valid;
        logic                is_far;
        logic                skip;
        logic [IDX_BITS-1:0] idx;
    } scan_ctl_t;
endpackage

>>> rtl/core/pcnn_dist.sv
// Pipelined squared distance and running best for one scan.
// Depends on pcnn_pkg.
module pcnn_dist #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcnn_pkg::scan_ctl_t                 ctl,
    input  logic signed [3*COORD_BITS-1:0]      ref_pt,
    input  logic signed [3*COORD_BITS-1:0]      cand_pt,
    output logic [pcnn_pkg::IDX_BITS-1:0]       best_index,
    output logic                                busy
);
    localparam int DB = COORD_BITS + 1;
    localparam int SB = 2 * DB + 2;

    logic signed [DB-1:0] d_reg [3];
    logic signed [DB-1:0] d_next [3];
    logic signed [2*DB-1:0] sq_next [3];
    logic [2*DB-1:0] sq_reg [3];
    logic [SB-1:0] sum;
    logic [1:0] vld_reg;
    logic [1:0] far_reg, skip_reg;
    logic [pcnn_pkg::IDX_BITS-1:0] i1_reg, i2_reg;
    logic [SB-1:0] best_reg;
    logic [pcnn_pkg::IDX_BITS-1:0] bidx_reg;
    logic found_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DB'(signed'(ref_pt[k*COORD_BITS +: COORD_BITS]))
                      - DB'(signed'(cand_pt[k*COORD_BITS +: COORD_BITS]));
            sq_next[k] = (2*DB)'(d_reg[k]) * (2*DB)'(d_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_reg[k]  <= d_next[k];
            sq_reg[k] <= $unsigned(sq_next[k]);
        end
        i1_reg <= ctl.idx;
        i2_reg <= i1_reg;
    end

    assign sum = SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0; far_reg <= '0; skip_reg <= '0;
            best_reg <= '0; bidx_reg <= '0; found_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[0], ctl.valid};
            far_reg  <= {far_reg[0], ctl.is_far};
            skip_reg <= {skip_reg[0], ctl.skip};
            if (ctl.start)
            begin
                best_reg <= '0; bidx_reg <= '0; found_reg <= 1'b0;
            end
            else if (vld_reg[1] && !skip_reg[1])
            begin
                if (far_reg[1] ? (sum > best_reg)
                               : (!found_reg || sum < best_reg))
                begin
                    best_reg <= sum; bidx_reg <= i2_reg;
                end
                found_reg <= 1'b1;
            end
        end
    end

    assign best_index = bidx_reg;
    assign busy = |vld_reg;
endmodule

>>> rtl/core/point_chain_nearest_neighbor_order.sv
// Point chain ordering: loads points (one cycle per request) until last_point,
// then emits them in greedy nearest-neighbor chain order. A scan sweeps every stored
// point with one memory read per cycle into a three-stage distance pipe (difference,
// square, sum and compare); output stalls hold the next scan. After the last point
// is emitted, a clear of all MAX_POINTS used marks runs before loading resumes.
// Reset is asynchronous, active low, runs the clear and then accepts requests.
`include "point_chain_nearest_neighbor_order_assert.svh"
module point_chain_nearest_neighbor_order #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic [5:0]                   source_index,
    output logic                         last_out
);
    localparam int IB = pcnn_pkg::IDX_BITS;
    localparam int CB = pcnn_pkg::CNT_BITS;
    localparam int PW = 3 * COORD_BITS;

    // Point memory, one write and one registered read per cycle.
    logic [PW-1:0] mem [MAX_POINTS];
    logic [PW-1:0] rd_data;
    logic [IB-1:0] rd_addr;
    logic          wr_en;
    // Used marks live in a second memory, read in step with the point memory.
    logic          used_mem [MAX_POINTS];
    logic          used_rd;
    logic          used_we;
    logic [IB-1:0] used_wa;
    logic          used_wd;

    pcnn_pkg::state_t state_reg, state_next;
    logic [CB-1:0] count_reg, count_next;
    logic [CB-1:0] scan_reg, scan_next;
    logic [CB-1:0] pos_reg, pos_next;
    logic [IB-1:0] fe_reg, fe_next, se_reg, se_next;
    logic [IB-1:0] emit_idx_reg, emit_idx_next;
    logic          emit_last_reg, emit_last_next;
    pcnn_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0] ref_reg;
    logic          ref_ld;
    logic          rd_vld_reg;
    logic [IB-1:0] rd_idx_reg;
    logic          rd_far_reg;
    logic          out_ld;
    logic          ovalid_reg;
    logic [PW-1:0] opt_reg;
    logic [IB-1:0] oidx_reg;
    logic          olast_reg;
    pcnn_pkg::scan_ctl_t ctl;
    logic [IB-1:0] best_index;
    logic          busy;
    logic          scanning;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IB-1:0]] <= {coord_z, coord_y, coord_x};
        rd_data <= mem[rd_addr];
        if (used_we)
            used_mem[used_wa] <= used_wd;
        used_rd <= used_mem[rd_addr];
        if (ref_ld)
            ref_reg <= rd_data;
        if (out_ld)
        begin
            opt_reg  <= rd_data;
            oidx_reg <= emit_idx_reg;
            olast_reg <= emit_last_reg;
        end
    end

    // Distance unit sees the read issued in the previous cycle.
    always_comb
    begin
        ctl.start  = 1'b0;
        ctl.valid  = rd_vld_reg;
        ctl.is_far = rd_far_reg;
        ctl.idx    = rd_idx_reg;
        ctl.skip   = !rd_far_reg && (used_rd || rd_idx_reg == fe_reg
                                     || rd_idx_reg == se_reg);
        if (scanning && scan_reg == '0)
            ctl.start = 1'b1;
    end

    pcnn_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .ref_pt(ref_reg),
        .cand_pt(rd_data), .best_index(best_index), .busy(busy)
    );

    assign scanning = (state_reg == pcnn_pkg::ST_FAR1 || state_reg == pcnn_pkg::ST_FAR2
                       || state_reg == pcnn_pkg::ST_NEAR)
                      && phase_reg == pcnn_pkg::PH_SWEEP;
    assign in_ready = state_reg == pcnn_pkg::ST_LOAD;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        pos_next = pos_reg;
        fe_next = fe_reg;
        se_next = se_reg;
        emit_idx_next = emit_idx_reg;
        emit_last_next = emit_last_reg;
        phase_next = phase_reg;
        rd_addr = '0;
        wr_en = 1'b0;
        ref_ld = 1'b0;
        out_ld = 1'b0;
        used_we = 1'b0;
        used_wa = emit_idx_reg;
        used_wd = 1'b1;
        unique case (state_reg)
            pcnn_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < CB'(MAX_POINTS))
                    begin
                        wr_en = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (last_point)
                    begin
                        phase_next = pcnn_pkg::PH_REF;
                        if (count_next == CB'(1))
                        begin
                            emit_idx_next = '0;
                            emit_last_next = 1'b1;
                            state_next = pcnn_pkg::ST_EMIT;
                        end
                        else
                            state_next = pcnn_pkg::ST_FAR1;
                    end
                end
            end
            pcnn_pkg::ST_FAR1, pcnn_pkg::ST_FAR2, pcnn_pkg::ST_NEAR:
            begin
                // The reference is read and latched, then every stored point
                // is swept, and the drain waits until the pipe is empty.
                unique case (phase_reg)
                    pcnn_pkg::PH_REF:
                    begin
                        if (state_reg == pcnn_pkg::ST_FAR1)
                            rd_addr = IB'(count_reg >> 1);
                        else
                            rd_addr = emit_idx_reg;
                        phase_next = pcnn_pkg::PH_FETCH;
                    end
                    pcnn_pkg::PH_FETCH:
                    begin
                        ref_ld = 1'b1;
                        scan_next = '0;
                        phase_next = pcnn_pkg::PH_SWEEP;
                    end
                    pcnn_pkg::PH_SWEEP:
                    begin
                        rd_addr = scan_reg[IB-1:0];
                        scan_next = scan_reg + 1'b1;
                        if (scan_next == count_reg)
                            phase_next = pcnn_pkg::PH_DRAIN;
                    end
                    pcnn_pkg::PH_DRAIN:
                    begin
                        if (!busy && !rd_vld_reg)
                        begin
                            phase_next = pcnn_pkg::PH_REF;
                            if (state_reg == pcnn_pkg::ST_FAR1)
                            begin
                                fe_next = best_index;
                                emit_idx_next = best_index;
                                state_next = pcnn_pkg::ST_FAR2;
                            end
                            else if (state_reg == pcnn_pkg::ST_FAR2)
                            begin
                                se_next = (best_index == fe_reg)
                                        ? ((fe_reg == '0) ? IB'(1) : '0) : best_index;
                                emit_last_next = 1'b0;
                                pos_next = CB'(1);
                                state_next = pcnn_pkg::ST_EMIT;
                            end
                            else
                            begin
                                emit_idx_next = best_index;
                                used_we = 1'b1;
                                used_wa = best_index;
                                pos_next = pos_reg + 1'b1;
                                state_next = pcnn_pkg::ST_EMIT;
                            end
                        end
                    end
                    default: phase_next = pcnn_pkg::PH_REF;
                endcase
            end
            pcnn_pkg::ST_EMIT:
            begin
                rd_addr = emit_idx_reg;
                if (!ovalid_reg)
                    state_next = pcnn_pkg::ST_WAIT;
            end
            pcnn_pkg::ST_WAIT:
            begin
                out_ld = 1'b1;
                if (emit_last_reg)
                begin
                    scan_next = '0;
                    state_next = pcnn_pkg::ST_CLEAR;
                end
                else if (pos_reg + 1'b1 < count_reg)
                begin
                    phase_next = pcnn_pkg::PH_REF;
                    state_next = pcnn_pkg::ST_NEAR;
                end
                else
                begin
                    emit_idx_next = se_reg;
                    emit_last_next = 1'b1;
                    state_next = pcnn_pkg::ST_EMIT;
                end
            end
            pcnn_pkg::ST_CLEAR:
            begin
                used_we = 1'b1;
                used_wa = scan_reg[IB-1:0];
                used_wd = 1'b0;
                scan_next = scan_reg + 1'b1;
                if (scan_next == CB'(MAX_POINTS))
                begin
                    count_next = '0;
                    state_next = pcnn_pkg::ST_LOAD;
                end
            end
            default: state_next = pcnn_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcnn_pkg::ST_CLEAR;
            count_reg <= '0; scan_reg <= '0; pos_reg <= '0;
            fe_reg <= '0; se_reg <= '0; emit_idx_reg <= '0;
            emit_last_reg <= 1'b0; phase_reg <= pcnn_pkg::PH_REF;
            rd_vld_reg <= 1'b0; rd_idx_reg <= '0; rd_far_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            pos_reg <= pos_next;
            fe_reg <= fe_next;
            se_reg <= se_next;
            emit_idx_reg <= emit_idx_next;
            emit_last_reg <= emit_last_next;
            phase_reg <= phase_next;
            rd_vld_reg <= scanning;
            rd_idx_reg <= scan_reg[IB-1:0];
            rd_far_reg <= state_reg != pcnn_pkg::ST_NEAR;
            if (out_ld)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_x = opt_reg[0 +: COORD_BITS];
    assign out_y = opt_reg[COORD_BITS +: COORD_BITS];
    assign out_z = opt_reg[2*COORD_BITS +: COORD_BITS];
    assign source_index = 6'(oidx_reg);
    assign last_out = olast_reg;

    `PCNN_ASSERT_IMP(a_load_only_idle, clk, rst_n, in_ready, !ovalid_reg || !busy)
    `PCNN_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_ld, !ovalid_reg)
    `PCNN_ASSERT_NXT(a_clear_done, clk, rst_n,
        state_reg == pcnn_pkg::ST_CLEAR && state_next == pcnn_pkg::ST_LOAD,
        count_reg == '0)
endmodule
